// ===== hw/rtl/sgfl_pkg.sv =====
// Shared types and constants for the sensor glitch filter with lockout.
// Holds field widths, register map codes, reset values and the lane result struct.
// No dependencies.
package sgfl_pkg;

    localparam int SENSOR_COUNT_DEF = 16;
    localparam int MASK_W           = 16;
    localparam int TIME_W           = 32;
    localparam int IN_DATA_W        = 48;
    localparam int OUT_DATA_W       = 64;
    localparam int ADDR_W           = 4;
    localparam int APB_DATA_W       = 32;

    localparam logic [1:0] REG_GLITCH_MS  = 2'd0;
    localparam logic [1:0] REG_LOCKOUT_MS = 2'd1;
    localparam logic [1:0] REG_USED_MASK  = 2'd2;

    localparam logic [TIME_W-1:0] GLITCH_MS_RST  = 32'd20;
    localparam logic [TIME_W-1:0] LOCKOUT_MS_RST = 32'd1000;
    localparam logic [MASK_W-1:0] USED_MASK_RST  = 16'hFFFF;

    typedef struct packed {
        logic active;
        logic changed;
        logic rise;
        logic fall;
        logic dirty;
    } t_lane_res;

endpackage

// ===== hw/rtl/sgfl_lane.sv =====
// One sensor slot: debounce timer, presence, lockout and sticky edge bits.
// Depends on sgfl_pkg for field widths and the lane result struct.
module sgfl_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_used,
    input  logic                           i_level,
    input  logic [sgfl_pkg::TIME_W-1:0]    i_now,
    input  logic                           i_clear,
    input  logic [sgfl_pkg::TIME_W-1:0]    i_glitch_ms,
    input  logic [sgfl_pkg::TIME_W-1:0]    i_lockout_ms,
    output sgfl_pkg::t_lane_res            o_res
);

    logic                        r_baseline, n_baseline;
    logic                        r_raw_prev, n_raw_prev;
    logic [sgfl_pkg::TIME_W-1:0] r_since, n_since;
    logic                        r_presence, n_presence;
    logic                        r_locked, n_locked;
    logic [sgfl_pkg::TIME_W-1:0] r_unlock, n_unlock;
    logic                        r_active, n_active;
    logic                        r_rise, n_rise;
    logic                        r_fall, n_fall;

    logic                        act;
    logic                        rise_c;
    logic                        fall_c;
    logic [sgfl_pkg::TIME_W-1:0] since_diff;
    logic [sgfl_pkg::TIME_W-1:0] unlock_diff;
    logic                        stable;
    logic                        still_locked;
    logic                        changed;

    always_comb begin
        act          = ~i_level;
        rise_c       = i_clear ? 1'b0 : r_rise;
        fall_c       = i_clear ? 1'b0 : r_fall;
        since_diff   = i_now - r_since;
        unlock_diff  = i_now - r_unlock;
        stable       = since_diff >= i_glitch_ms;
        // The lockout ends once the timestamp has reached the unlock time.
        still_locked = r_locked & unlock_diff[sgfl_pkg::TIME_W-1];

        n_baseline = r_baseline;
        n_raw_prev = r_raw_prev;
        n_since    = r_since;
        n_presence = r_presence;
        n_locked   = r_locked;
        n_unlock   = r_unlock;
        n_active   = r_active;
        n_rise     = rise_c;
        n_fall     = fall_c;
        changed    = 1'b0;

        priority if (!i_used) begin
            n_presence = 1'b0;
        end else if (!r_baseline) begin
            n_baseline = 1'b1;
            n_raw_prev = act;
            n_since    = i_now;
            n_presence = act;
            n_active   = act;
        end else if (act != r_raw_prev) begin
            n_raw_prev = act;
            n_since    = i_now;
        end else if (stable) begin
            n_locked = still_locked;
            if (act && !r_presence) begin
                n_presence = 1'b1;
                if (!still_locked) begin
                    n_active = 1'b1;
                    changed  = 1'b1;
                    n_rise   = 1'b1;
                    n_locked = 1'b1;
                    n_unlock = i_now + i_lockout_ms;
                end
            end else if (!act && r_presence) begin
                n_presence = 1'b0;
                n_active   = 1'b0;
                n_fall     = 1'b1;
            end
        end else begin
            // A level that has not settled yet leaves the slot as it is.
        end

        o_res.active  = n_active;
        o_res.changed = changed;
        o_res.rise    = n_rise;
        o_res.fall    = n_fall;
        o_res.dirty   = (n_active != r_active) || (n_rise != rise_c) || (n_fall != fall_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 1'b0;
            r_raw_prev <= 1'b0;
            r_presence <= 1'b0;
            r_locked   <= 1'b0;
            r_active   <= 1'b0;
            r_rise     <= 1'b0;
            r_fall     <= 1'b0;
        end else if (i_accept) begin
            r_baseline <= n_baseline;
            r_raw_prev <= n_raw_prev;
            r_presence <= n_presence;
            r_locked   <= n_locked;
            r_active   <= n_active;
            r_rise     <= n_rise;
            r_fall     <= n_fall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_since  <= n_since;
            r_unlock <= n_unlock;
        end
    end

    a_lock_needs_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> r_baseline)
        else $error("slot locked before its baseline was taken");

    a_unused_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_used) |=> !r_presence)
        else $error("unused slot kept its presence");

    a_trigger_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res.changed) |=> (r_locked && r_active && r_rise))
        else $error("triggered entry did not lock and mark the slot");

endmodule

// ===== hw/rtl/sgfl_merge.sv =====
// Merges the lane results into one result transaction and holds it in an
// output register backed by a one-entry skid stage. Depends on sgfl_pkg.
module sgfl_merge #(
    parameter int LANES = sgfl_pkg::SENSOR_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sgfl_pkg::t_lane_res               i_lane_res [LANES],
    input  logic                              i_accept,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sgfl_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_dirty
);

    logic [sgfl_pkg::MASK_W-1:0]     active_m, changed_m, rise_m, fall_m;
    logic                            dirty_any;
    logic [sgfl_pkg::OUT_DATA_W-1:0] new_data;

    logic                            r_out_valid;
    logic [sgfl_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_dirty;
    logic                            r_skid_valid;
    logic [sgfl_pkg::OUT_DATA_W-1:0] r_skid_data;
    logic                            r_skid_dirty;
    logic                            out_take;

    always_comb begin
        active_m  = '0;
        changed_m = '0;
        rise_m    = '0;
        fall_m    = '0;
        dirty_any = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            active_m[i]  = i_lane_res[i].active;
            changed_m[i] = i_lane_res[i].changed;
            rise_m[i]    = i_lane_res[i].rise;
            fall_m[i]    = i_lane_res[i].fall;
            dirty_any    = dirty_any | i_lane_res[i].dirty;
        end
        new_data = {fall_m, rise_m, changed_m, active_m};
    end

    assign out_take    = r_out_valid & i_out_ready;
    assign o_in_ready  = ~r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_dirty = r_out_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_accept;
                end
            end else if (i_accept) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_skid_valid) begin
            r_out_data  <= r_skid_data;
            r_out_dirty <= r_skid_dirty;
        end else if (i_accept && (out_take || !r_out_valid)) begin
            r_out_data  <= new_data;
            r_out_dirty <= dirty_any;
        end
        if (i_accept && r_out_valid && !out_take) begin
            r_skid_data  <= new_data;
            r_skid_dirty <= dirty_any;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result accepted under a stall was not kept in the skid stage");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not move into the output register");

endmodule

// ===== hw/rtl/sensor_glitch_filter_lockout_unit.sv =====
// Top level of the sensor glitch filter with lockout: register file, one lane
// per sensor slot and the result merge stage. Depends on sgfl_pkg, sgfl_lane, sgfl_merge.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: raw_levels[15:0], now_ms[47:16]; tuser: clear_edges
//  m_axis   out        tdata: active[15:0], changed[31:16], rise[47:32], fall[63:48];
//                      tuser: diag_dirty
//  apb      in/out     0x0 glitch_ms, 0x4 lockout_ms, 0x8 used_mask
//
// One sample is accepted per cycle while s_axis_tready is high; its result is
// registered in the output register, or in the skid stage while the output
// is stalled. All lanes update their slot state in the accepting cycle.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled output keeps one more result in a skid stage; s_axis_tready
// drops only while both the output register and the skid stage are full.
module sensor_glitch_filter_lockout_unit #(
    parameter int SENSOR_COUNT = sgfl_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // raw_levels [15:0], now_ms [47:16]
    input  logic [sgfl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // clear_edges [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // active_mask [15:0], changed_mask [31:16], rise_mask [47:32], fall_mask [63:48]
    output logic [sgfl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // diag_dirty [0]
    output logic                                m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sgfl_pkg::ADDR_W-1:0]         paddr,
    input  logic [sgfl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sgfl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int LANES = (SENSOR_COUNT < sgfl_pkg::MASK_W) ? SENSOR_COUNT
                                                               : sgfl_pkg::MASK_W;

    logic [sgfl_pkg::TIME_W-1:0] r_glitch_ms;
    logic [sgfl_pkg::TIME_W-1:0] r_lockout_ms;
    logic [sgfl_pkg::MASK_W-1:0] r_used_mask;

    logic                        cfg_write;
    logic [1:0]                  reg_idx;
    logic                        in_accept;
    logic [sgfl_pkg::MASK_W-1:0] raw_levels;
    logic [sgfl_pkg::TIME_W-1:0] now_ms;
    sgfl_pkg::t_lane_res         lane_res [LANES];

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_ms  <= sgfl_pkg::GLITCH_MS_RST;
            r_lockout_ms <= sgfl_pkg::LOCKOUT_MS_RST;
            r_used_mask  <= sgfl_pkg::USED_MASK_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                sgfl_pkg::REG_GLITCH_MS:  r_glitch_ms  <= pwdata;
                sgfl_pkg::REG_LOCKOUT_MS: r_lockout_ms <= pwdata;
                sgfl_pkg::REG_USED_MASK:  r_used_mask  <= pwdata[sgfl_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sgfl_pkg::REG_GLITCH_MS:  prdata = r_glitch_ms;
            sgfl_pkg::REG_LOCKOUT_MS: prdata = r_lockout_ms;
            sgfl_pkg::REG_USED_MASK:  prdata = {{(sgfl_pkg::APB_DATA_W-sgfl_pkg::MASK_W){1'b0}},
                                                r_used_mask};
            default:                  prdata = '0;
        endcase
    end

    assign in_accept  = s_axis_tvalid & s_axis_tready;
    assign raw_levels = s_axis_tdata[sgfl_pkg::MASK_W-1:0];
    assign now_ms     = s_axis_tdata[sgfl_pkg::IN_DATA_W-1:sgfl_pkg::MASK_W];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sgfl_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_accept     (in_accept),
            .i_used       (r_used_mask[g]),
            .i_level      (raw_levels[g]),
            .i_now        (now_ms),
            .i_clear      (s_axis_tuser),
            .i_glitch_ms  (r_glitch_ms),
            .i_lockout_ms (r_lockout_ms),
            .o_res        (lane_res[g])
        );
    end

    sgfl_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lane_res  (lane_res),
        .i_accept    (in_accept),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_dirty (m_axis_tuser)
    );

endmodule
